// ===== hdl/hlps_pkg.sv =====
// Shared types, codes and defaults for the heater level and power mode controller.
`default_nettype none
package hlps_pkg;

  localparam int NUM_LEVELS_DEF    = 9;
  localparam int SAMPLE_PERIOD_DEF = 10;

  localparam int IN_W  = 8;
  localparam int OUT_W = 16;

  // Input operation codes.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BUTTON = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_IDLE_TICKS  = 2'd0;
  localparam logic [1:0] REG_SLEEP_TICKS = 2'd1;
  localparam logic [1:0] REG_BLINK_STEPS = 2'd2;

  localparam logic [31:0] IDLE_TICKS_RST  = 32'd6000;
  localparam logic [31:0] SLEEP_TICKS_RST = 32'd30000;
  localparam logic [15:0] BLINK_STEPS_RST = 16'd100;

  // Mode codes as they appear on the result channel.
  localparam logic [1:0] MODE_CODE_SLEEP = 2'd0;
  localparam logic [1:0] MODE_CODE_IDLE  = 2'd1;
  localparam logic [1:0] MODE_CODE_HEAT  = 2'd2;

  typedef enum logic [2:0] {
    MODE_SLEEP = 3'b001,
    MODE_IDLE  = 3'b010,
    MODE_HEAT  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [31:0] idle_ticks;
    logic [31:0] sleep_ticks;
    logic [15:0] blink_steps;
  } cfg_t;

  // Listed from the highest bit down, so the opcode sits in the lowest bits.
  typedef struct packed {
    logic       moved;
    logic       down_pressed;
    logic       up_pressed;
    logic [1:0] opcode;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  cur_level;
    logic [3:0]  rem_level;
    logic [31:0] inact_cnt;
    logic [15:0] blink_cnt;
    logic [3:0]  phase;
    logic        blank;
  } state_t;

  typedef struct packed {
    logic       sensor_restart;
    logic       start_sample;
    logic       drive_blanked;
    logic       heat_request;
    logic       led_on;
    logic [3:0] level;
    logic [1:0] mode;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/hlps_cfg_regs.sv =====
// Configuration register file with its write channel.
`default_nettype none
module hlps_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output hlps_pkg::cfg_t     cfg
);

  hlps_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_ticks  <= hlps_pkg::IDLE_TICKS_RST;
      cfg_r.sleep_ticks <= hlps_pkg::SLEEP_TICKS_RST;
      cfg_r.blink_steps <= hlps_pkg::BLINK_STEPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hlps_pkg::REG_IDLE_TICKS:  cfg_r.idle_ticks  <= cfg_data;
        hlps_pkg::REG_SLEEP_TICKS: cfg_r.sleep_ticks <= cfg_data;
        hlps_pkg::REG_BLINK_STEPS: cfg_r.blink_steps <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hlps_next.sv =====
// Single-pass next-state and result logic for one input item.
`default_nettype none
module hlps_next #(
  parameter int NUM_LEVELS    = hlps_pkg::NUM_LEVELS_DEF,
  parameter int SAMPLE_PERIOD = hlps_pkg::SAMPLE_PERIOD_DEF
) (
  input  hlps_pkg::state_t  st,
  input  hlps_pkg::item_t   item,
  input  hlps_pkg::cfg_t    cfg,
  output hlps_pkg::state_t  st_nxt,
  output hlps_pkg::result_t res
);

  localparam logic [3:0] TOP_LEVEL = 4'(NUM_LEVELS - 1);
  localparam logic [3:0] PH_BLANK  = 4'(SAMPLE_PERIOD - 1);
  localparam logic [3:0] PH_END    = 4'(SAMPLE_PERIOD);

  logic [3:0]  phase_inc;
  logic [31:0] cnt_inc;
  logic        led, heat, start, restart;

  assign phase_inc = st.phase + 4'd1;
  assign cnt_inc   = st.inact_cnt + 32'd1;

  always_comb begin
    st_nxt  = st;
    led     = 1'b0;
    heat    = 1'b0;
    start   = 1'b0;
    restart = 1'b0;
    case (item.opcode)
      hlps_pkg::OP_TICK: begin
        st_nxt.phase = phase_inc;
        if (phase_inc == PH_BLANK) begin
          st_nxt.blank = 1'b1;
        end else if (phase_inc == PH_END) begin
          start        = 1'b1;
          st_nxt.phase = 4'd0;
          st_nxt.blank = 1'b0;
        end
        st_nxt.inact_cnt = cnt_inc;
        if (cnt_inc == cfg.idle_ticks && st.mode == hlps_pkg::MODE_HEAT) begin
          st_nxt.mode      = hlps_pkg::MODE_IDLE;
          st_nxt.inact_cnt = 32'd0;
        end
        // The sleep check sees the counter after a possible idle entry.
        if (st_nxt.inact_cnt == cfg.sleep_ticks && st_nxt.mode == hlps_pkg::MODE_IDLE) begin
          st_nxt.mode      = hlps_pkg::MODE_SLEEP;
          st_nxt.inact_cnt = 32'd0;
        end
      end
      hlps_pkg::OP_BUTTON: begin
        if ((st.mode == hlps_pkg::MODE_SLEEP && item.up_pressed) ||
            st.mode == hlps_pkg::MODE_IDLE) begin
          st_nxt.mode      = hlps_pkg::MODE_HEAT;
          st_nxt.cur_level = st.rem_level;
        end else if (item.down_pressed && st.mode == hlps_pkg::MODE_HEAT &&
                     st.cur_level != 4'd0) begin
          st_nxt.cur_level = st.cur_level - 4'd1;
        end else if (item.up_pressed && st.mode == hlps_pkg::MODE_HEAT &&
                     st.cur_level < TOP_LEVEL) begin
          st_nxt.cur_level = st.cur_level + 4'd1;
        end
        st_nxt.inact_cnt = 32'd0;
      end
      hlps_pkg::OP_STEP: begin
        unique case (st.mode)
          hlps_pkg::MODE_SLEEP: restart = 1'b1;
          hlps_pkg::MODE_IDLE: begin
            led = (st.blink_cnt < (cfg.blink_steps >> 1));
            if (st.blink_cnt > cfg.blink_steps) begin
              st_nxt.blink_cnt = 16'd0;
            end else begin
              st_nxt.blink_cnt = st.blink_cnt + 16'd1;
            end
            if (item.moved) begin
              st_nxt.mode      = hlps_pkg::MODE_HEAT;
              st_nxt.cur_level = st.rem_level;
              st_nxt.blink_cnt = 16'd0;
            end
          end
          hlps_pkg::MODE_HEAT: begin
            st_nxt.rem_level = st.cur_level;
            led              = 1'b1;
            heat             = 1'b1;
            if (item.moved) begin
              st_nxt.inact_cnt = 32'd0;
            end
          end
          default: st_nxt.mode = hlps_pkg::MODE_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (st_nxt.mode)
      hlps_pkg::MODE_SLEEP: res.mode = hlps_pkg::MODE_CODE_SLEEP;
      hlps_pkg::MODE_IDLE:  res.mode = hlps_pkg::MODE_CODE_IDLE;
      hlps_pkg::MODE_HEAT:  res.mode = hlps_pkg::MODE_CODE_HEAT;
      default:              res.mode = hlps_pkg::MODE_CODE_IDLE;
    endcase
    res.level          = (st_nxt.mode == hlps_pkg::MODE_HEAT) ? st_nxt.cur_level
                                                              : st_nxt.rem_level;
    res.led_on         = led;
    res.heat_request   = heat;
    res.drive_blanked  = st_nxt.blank;
    res.start_sample   = start;
    res.sensor_restart = restart;
  end

endmodule
`default_nettype wire

// ===== hdl/hlps_out_reg.sv =====
// Result register that decouples the result channel from the input channel.
`default_nettype none
module hlps_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  hlps_pkg::result_t  res,
  output logic               space,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata
);

  logic              valid_r;
  hlps_pkg::result_t res_r;

  // A new result may enter when the register is empty or is being drained.
  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {5'd0, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/heater_level_power_state_machine_core.sv =====
// Top level of the heater level and power mode controller.
//
// Items arrive on the in_ stream: each is a timer tick, a button event or a
// control step, chosen by the opcode. Every accepted item yields exactly one
// result on the out_ stream, showing the mode and level after the item and the
// per-item flags (LED, heat request, drive blanking, sample start, sensor
// restart). Thresholds are written on the cfg_ port, which is always ready and
// should only be written while no result is outstanding.
// The state and the result register are both updated at the edge where the input
// transfer completes, and the result is shown on the next cycle. Throughput is
// one item per cycle while the receiver keeps taking results, set by the single
// pass of the next-state logic (a 32-bit increment and two compares) into the
// result register. A stalled receiver holds the result register; in_tready stays
// high while the register is empty or drained in the same cycle, so a new item
// still enters when a result is taken. Reset puts the block in sleep at level
// zero with all counters cleared and the configuration at its defaults.
`default_nettype none
module heater_level_power_state_machine_core #(
  parameter int NUM_LEVELS    = hlps_pkg::NUM_LEVELS_DEF,
  parameter int SAMPLE_PERIOD = hlps_pkg::SAMPLE_PERIOD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[1:0], up_pressed[2], down_pressed[3], moved[4], zero[7:5]
  input  wire logic [7:0]  in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mode[1:0], level[5:2], led_on[6], heat_request[7], drive_blanked[8],
  // start_sample[9], sensor_restart[10], zero[15:11]
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  hlps_pkg::cfg_t    cfg;
  hlps_pkg::item_t   item;
  hlps_pkg::state_t  st_r, st_nxt;
  hlps_pkg::result_t res;
  logic              space;
  logic              in_xfer;

  assign item      = in_tdata[4:0];
  assign in_tready = space;
  assign in_xfer   = in_tvalid && space;

  hlps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hlps_next #(
    .NUM_LEVELS    (NUM_LEVELS),
    .SAMPLE_PERIOD (SAMPLE_PERIOD)
  ) u_next (
    .st     (st_r),
    .item   (item),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode      <= hlps_pkg::MODE_SLEEP;
      st_r.cur_level <= 4'd0;
      st_r.rem_level <= 4'd0;
      st_r.inact_cnt <= 32'd0;
      st_r.blink_cnt <= 16'd0;
      st_r.phase     <= 4'd0;
      st_r.blank     <= 1'b0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  hlps_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/hlps_checker.sv =====
// Port-level checker for the controller and its bind to the top level.
`default_nettype none
module hlps_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("unused mode code on result");

  // The LED is only driven on control steps, the sample start only on ticks.
  a_flag_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[9] && (out_tdata[6] || out_tdata[7] || out_tdata[10])))
    else $error("tick flag and control step flag on one result");

endmodule

bind heater_level_power_state_machine_core hlps_checker u_hlps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
